FILE: rtl/brsp_pkg.sv
// Shared types and constants for the base relocation stream parser.
package brsp_pkg;

  // Header and entry layout
  localparam logic [31:0] HEADER_BYTES     = 32'd8;
  localparam logic [3:0]  RELOC_TYPE_DIR64 = 4'd10;
  localparam logic [3:0]  RELOC_TYPE_PAD   = 4'd0;
  localparam logic [11:0] OFFSET_MASK      = 12'hFFF;
  localparam int          TYPE_SHIFT       = 12;

  // Saturating event counts
  localparam int          COUNT_W   = 31;
  localparam logic [30:0] COUNT_MAX = 31'h7FFF_FFFF;

  // Result queue sizing
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = 2;
  localparam int RQ_CNT_W = 3;

  // Result kinds
  localparam logic KIND_TARGET  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic                result_kind;
    logic [32:0]         slot_addr;
    logic [COUNT_W-1:0]  dir64_total;
    logic [COUNT_W-1:0]  other_total;
    logic                stopped_malformed;
    logic                last_result;
  } result_t;

endpackage

FILE: rtl/brsp_if.sv
// Input and result stream interfaces of the base relocation stream parser.
interface brsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface brsp_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [32:0] slot_addr;
  logic [30:0] dir64_total;
  logic [30:0] other_total;
  logic        stopped_malformed;
  logic        last_result;

  modport source (output valid, output result_kind, output slot_addr,
                  output dir64_total, output other_total,
                  output stopped_malformed, output last_result, input ready);
  modport sink   (input valid, input result_kind, input slot_addr,
                  input dir64_total, input other_total,
                  input stopped_malformed, input last_result, output ready);
endinterface

FILE: rtl/base_relocation_stream_parser.sv
// Top level: streaming PE64 base relocation table parser with result queue.
//
// Usage:
//   in_ch carries the table one byte per beat, in file order; final_byte
//   marks the last byte of the table. out_ch carries results: a DIR64
//   target (page RVA plus 12-bit offset) for each type-10 entry, and an
//   end-of-table summary of the counts after the final byte.
//   Each accepted byte is parsed in the cycle it is taken; its results are
//   written into a four-entry result queue, whose head drives out_ch.
//   A byte is accepted every cycle while the queue holds at most two
//   results, so the block sustains one byte per clock as long as the
//   receiver takes one result per clock. A final byte that also completes a
//   DIR64 entry gives two results, which leave the queue target first.
//   When the receiver stalls, the queue fills and in_ch.ready drops once
//   three results wait; the head result holds on out_ch until taken.
//   Reset (rst_n low, synchronous) clears the parse state, the counts and
//   the queue. After the final byte the parse state also returns to reset,
//   so the next byte starts a new table.
module base_relocation_stream_parser (
  input  logic            clk,
  input  logic            rst_n,
  brsp_in_if.sink         in_ch,
  brsp_out_if.source      out_ch
);
  import brsp_pkg::*;

  // Parse state
  logic [31:0]        byte_in_block_r, byte_in_block_nxt;
  logic [31:0]        page_rva_r, page_rva_nxt;
  logic [31:0]        block_length_r, block_length_nxt;
  logic [7:0]         entry_low_byte_r, entry_low_byte_nxt;
  logic               halted_r, halted_nxt;
  logic [COUNT_W-1:0] dir64_count_r, dir64_count_nxt;
  logic [COUNT_W-1:0] other_count_r, other_count_nxt;

  // Result queue
  result_t             rq_mem_r [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] rq_head_r, rq_tail_r;
  logic [RQ_CNT_W-1:0] rq_cnt_r, rq_cnt_nxt;

  logic        in_beat, out_beat;
  logic [31:0] pos, pos_inc;
  logic [15:0] entry;
  logic [3:0]  entry_type;
  logic [11:0] entry_off;
  logic        push_target, push_summary;
  result_t     target_res, summary_res;
  result_t     head_res;

  assign in_beat  = in_ch.valid && in_ch.ready;
  assign out_beat = out_ch.valid && out_ch.ready;
  assign pos      = byte_in_block_r;
  assign pos_inc  = byte_in_block_r + 32'd1;
  assign entry      = {in_ch.data_byte, entry_low_byte_r};
  assign entry_type = entry[15:TYPE_SHIFT];
  assign entry_off  = entry[11:0] & OFFSET_MASK;

  // Parse one byte and build its results
  always_comb begin
    byte_in_block_nxt  = byte_in_block_r;
    page_rva_nxt       = page_rva_r;
    block_length_nxt   = block_length_r;
    entry_low_byte_nxt = entry_low_byte_r;
    halted_nxt         = halted_r;
    dir64_count_nxt    = dir64_count_r;
    other_count_nxt    = other_count_r;
    push_target        = 1'b0;
    push_summary       = 1'b0;
    target_res         = '0;
    summary_res        = '0;

    if (in_beat) begin
      if (!halted_r) begin
        if (pos < 32'd4) begin
          page_rva_nxt[{pos[1:0], 3'b000} +: 8] = in_ch.data_byte;
          byte_in_block_nxt = pos_inc;
        end else if (pos < HEADER_BYTES) begin
          block_length_nxt[{pos[1:0], 3'b000} +: 8] = in_ch.data_byte;
          byte_in_block_nxt = pos_inc;
          if (pos == HEADER_BYTES - 32'd1) begin
            if (block_length_nxt < HEADER_BYTES) begin
              halted_nxt = 1'b1;
            end else if (block_length_nxt == HEADER_BYTES) begin
              byte_in_block_nxt = '0;
            end
          end
        end else begin
          if (!pos[0]) begin
            entry_low_byte_nxt = in_ch.data_byte;
          end else if (entry_type == RELOC_TYPE_DIR64) begin
            if (dir64_count_r != COUNT_MAX) begin
              dir64_count_nxt = dir64_count_r + COUNT_W'(1);
            end
            push_target = 1'b1;
          end else if (entry_type != RELOC_TYPE_PAD) begin
            if (other_count_r != COUNT_MAX) begin
              other_count_nxt = other_count_r + COUNT_W'(1);
            end
          end
          byte_in_block_nxt = (pos_inc >= block_length_r) ? '0 : pos_inc;
        end
      end

      target_res.result_kind       = KIND_TARGET;
      target_res.slot_addr         = {1'b0, page_rva_r} + {21'd0, entry_off};
      target_res.dir64_total       = dir64_count_nxt;
      target_res.other_total       = other_count_nxt;
      target_res.stopped_malformed = 1'b0;
      target_res.last_result       = !in_ch.final_byte;

      summary_res.result_kind       = KIND_SUMMARY;
      summary_res.slot_addr         = '0;
      summary_res.dir64_total       = dir64_count_nxt;
      summary_res.other_total       = other_count_nxt;
      summary_res.stopped_malformed = halted_nxt;
      summary_res.last_result       = 1'b1;

      // Close the table: emit summary, then drop back to reset state
      if (in_ch.final_byte) begin
        push_summary       = 1'b1;
        byte_in_block_nxt  = '0;
        page_rva_nxt       = '0;
        block_length_nxt   = '0;
        entry_low_byte_nxt = '0;
        halted_nxt         = 1'b0;
        dir64_count_nxt    = '0;
        other_count_nxt    = '0;
      end
    end
  end

  // Hold parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_in_block_r  <= '0;
      page_rva_r       <= '0;
      block_length_r   <= '0;
      entry_low_byte_r <= '0;
      halted_r         <= 1'b0;
      dir64_count_r    <= '0;
      other_count_r    <= '0;
    end else begin
      byte_in_block_r  <= byte_in_block_nxt;
      page_rva_r       <= page_rva_nxt;
      block_length_r   <= block_length_nxt;
      entry_low_byte_r <= entry_low_byte_nxt;
      halted_r         <= halted_nxt;
      dir64_count_r    <= dir64_count_nxt;
      other_count_r    <= other_count_nxt;
    end
  end

  // Count queue occupancy: up to two pushes and one pop per cycle
  always_comb begin
    rq_cnt_nxt = rq_cnt_r + RQ_CNT_W'(push_target) + RQ_CNT_W'(push_summary)
                 - RQ_CNT_W'(out_beat);
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_head_r <= '0;
      rq_tail_r <= '0;
      rq_cnt_r  <= '0;
    end else begin
      rq_cnt_r  <= rq_cnt_nxt;
      rq_tail_r <= rq_tail_r + RQ_PTR_W'(push_target) + RQ_PTR_W'(push_summary);
      if (out_beat) begin
        rq_head_r <= rq_head_r + RQ_PTR_W'(1);
      end
    end
  end

  // Write results in order: target first, summary after it
  always_ff @(posedge clk) begin
    if (push_target) begin
      rq_mem_r[rq_tail_r] <= target_res;
    end
    if (push_summary) begin
      rq_mem_r[rq_tail_r + RQ_PTR_W'(push_target)] <= summary_res;
    end
  end

  // Drive the result channel from the queue head
  assign head_res                 = rq_mem_r[rq_head_r];
  assign out_ch.valid             = (rq_cnt_r != '0);
  assign out_ch.result_kind       = head_res.result_kind;
  assign out_ch.slot_addr         = head_res.slot_addr;
  assign out_ch.dir64_total       = head_res.dir64_total;
  assign out_ch.other_total       = head_res.other_total;
  assign out_ch.stopped_malformed = head_res.stopped_malformed;
  assign out_ch.last_result       = head_res.last_result;

  // Take a byte only while room for two results remains
  assign in_ch.ready = (rq_cnt_r <= RQ_CNT_W'(RQ_DEPTH - 2));

endmodule

FILE: rtl/brsp_checker.sv
// Port-level checker for the base relocation stream parser, with its bind.
module brsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        result_kind,
  input logic [32:0] slot_addr,
  input logic [30:0] dir64_total,
  input logic [30:0] other_total,
  input logic        stopped_malformed,
  input logic        last_result
);
  import brsp_pkg::*;

  // A stalled result beat holds its valid and payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) &&
      $stable(slot_addr) && $stable(dir64_total) && $stable(other_total) &&
      $stable(stopped_malformed) && $stable(last_result))
    else $error("result beat changed while stalled");

  // A summary carries no target and closes the byte's results
  a_summary_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_kind == KIND_SUMMARY |-> slot_addr == '0 && last_result)
    else $error("summary beat malformed");

  // A DIR64 target never reports a halt and always counts itself
  a_target_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_kind == KIND_TARGET |-> !stopped_malformed && dir64_total != '0)
    else $error("target beat malformed");

  // Reset empties the result queue
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind base_relocation_stream_parser brsp_checker u_brsp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .result_kind       (out_ch.result_kind),
  .slot_addr         (out_ch.slot_addr),
  .dir64_total       (out_ch.dir64_total),
  .other_total       (out_ch.other_total),
  .stopped_malformed (out_ch.stopped_malformed),
  .last_result       (out_ch.last_result)
);
